[src/fens_pkg.sv]
// Package for the filtered insertion sort block.
// Holds the sizes, the sequencer state type and the memory control struct.
// No dependencies.
package fens_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int DATA_W       = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_PUT,
    ST_EMIT_RD,
    ST_EMIT_LD
  } fens_state_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

[src/fens_mem.sv]
// Kept-value store: one write port, one read port with registered data.
// Depends on fens_pkg.
module fens_mem
  import fens_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic              clk,
  input  mem_ctl_t          mem_ctl,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/fens_cmp.sv]
// Shared signed compare used by every step of the insertion walk.
// Depends on fens_pkg.
module fens_cmp
  import fens_pkg::*;
(
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output logic              gt
);

  // flip sign bits so an unsigned compare gives signed order
  assign gt = ({~a[DATA_W-1], a[DATA_W-2:0]} > {~b[DATA_W-1], b[DATA_W-2:0]});

endmodule

[src/fens_ctrl.sv]
// Sequencer: filter, insertion walk over the store, ordered emission and
// the output register. Depends on fens_pkg; drives fens_mem and fens_cmp.
module fens_ctrl
  import fens_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,
  output logic              out_tlast,
  output logic [1:0]        out_tuser,
  output mem_ctl_t          mem_ctl,
  output logic [AW-1:0]     waddr,
  output logic [DATA_W-1:0] wdata,
  output logic [AW-1:0]     raddr,
  input  logic [DATA_W-1:0] rdata,
  output logic [DATA_W-1:0] cmp_a,
  output logic [DATA_W-1:0] cmp_b,
  input  logic              cmp_gt
);

  fens_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic              drop_r, drop_nxt;
  logic              lastp_r, lastp_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [DATA_W-1:0] odata_r, odata_nxt;
  logic              olast_r, olast_nxt;
  logic [1:0]        ouser_r, ouser_nxt;

  logic             kept;
  logic             full;
  logic             empty;
  logic             fin;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] pos_m1;
  logic [CNT_W-1:0] pos_m2;

  assign kept   = in_tdata[DATA_W-1] | ~in_tdata[0];
  assign full   = (cnt_r == CNT_W'(CAPACITY));
  assign empty  = (cnt_r == '0);
  assign cnt_m1 = cnt_r - CNT_W'(1);
  assign pos_m1 = pos_r - CNT_W'(1);
  assign pos_m2 = pos_r - CNT_W'(2);
  assign fin    = empty || (CNT_W'(idx_r) == cnt_m1);

  assign cmp_a = rdata;
  assign cmp_b = val_r;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = ouser_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      drop_r   <= 1'b0;
      lastp_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      drop_r   <= drop_nxt;
      lastp_r  <= lastp_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    idx_r   <= idx_nxt;
    val_r   <= val_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
    ouser_r <= ouser_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    idx_nxt    = idx_r;
    val_nxt    = val_r;
    drop_nxt   = drop_r;
    lastp_nxt  = lastp_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    ouser_nxt  = ouser_r;
    mem_ctl    = '0;
    waddr      = '0;
    wdata      = val_r;
    raddr      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          val_nxt   = in_tdata;
          lastp_nxt = in_tlast;
          idx_nxt   = '0;
          if (kept && !full) begin
            if (empty) begin
              mem_ctl.we = 1'b1;
              waddr      = '0;
              wdata      = in_tdata;
              cnt_nxt    = cnt_r + CNT_W'(1);
              if (in_tlast) begin
                state_nxt = ST_EMIT_RD;
              end
            end else begin
              // start the walk at the top entry
              mem_ctl.re = 1'b1;
              raddr      = cnt_m1[AW-1:0];
              pos_nxt    = cnt_r;
              state_nxt  = ST_INS;
            end
          end else begin
            if (kept) begin
              drop_nxt = 1'b1;
            end
            if (in_tlast) begin
              state_nxt = ST_EMIT_RD;
            end
          end
        end
      end

      ST_INS: begin
        mem_ctl.we = 1'b1;
        waddr      = pos_r[AW-1:0];
        if (cmp_gt) begin
          // move the larger word up one slot and keep walking down
          wdata   = rdata;
          pos_nxt = pos_m1;
          if (pos_r == CNT_W'(1)) begin
            state_nxt = ST_PUT;
          end else begin
            mem_ctl.re = 1'b1;
            raddr      = pos_m2[AW-1:0];
          end
        end else begin
          wdata     = val_r;
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = lastp_r ? ST_EMIT_RD : ST_IDLE;
        end
      end

      ST_PUT: begin
        mem_ctl.we = 1'b1;
        waddr      = '0;
        wdata      = val_r;
        cnt_nxt    = cnt_r + CNT_W'(1);
        state_nxt  = lastp_r ? ST_EMIT_RD : ST_IDLE;
      end

      ST_EMIT_RD: begin
        if (!empty) begin
          mem_ctl.re = 1'b1;
          raddr      = idx_r;
        end
        state_nxt = ST_EMIT_LD;
      end

      ST_EMIT_LD: begin
        // load only when the output register is free or draining
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = empty ? '0 : rdata;
          olast_nxt  = fin;
          ouser_nxt  = {drop_r, empty};
          if (fin) begin
            cnt_nxt   = '0;
            drop_nxt  = 1'b0;
            lastp_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[src/filter_even_negative_then_sort.sv]
// Top level of the filtered insertion sort: keeps negative or even words,
// sorts them on insertion and emits them in ascending order.
// Depends on fens_pkg, fens_mem, fens_cmp and fens_ctrl.
//
// channel  dir  ports                          fields (lowest bit up)
// in       in   in_tvalid/in_tready/in_tdata   tdata: value[31:0]; tlast: last
// out      out  out_tvalid/out_tready/...      tdata: sorted_value[31:0];
//                                              tlast: final_res;
//                                              tuser: empty_res, overflow
//
// A word that is dropped by the filter, or by a full store, is not written to
// the store. A kept word goes straight into an empty store; otherwise the
// single compare unit walks the store down from the top, one entry per cycle,
// moving each stored word larger than it up one slot.
// Each result is emitted by a memory read, then an output register load.
// in_tready is low during insertion and emission; a stall on the output holds
// the sequencer. Synchronous active-low reset clears count, flags and valid.
module filter_even_negative_then_sort
  import fens_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // value[31:0]
  input  logic              in_tlast,   // last
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // sorted_value[31:0]
  output logic              out_tlast,  // final_res
  output logic [1:0]        out_tuser   // [0] empty_res, [1] overflow
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  mem_ctl_t          mem_ctl;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;
  logic [DATA_W-1:0] cmp_a;
  logic [DATA_W-1:0] cmp_b;
  logic              cmp_gt;

  fens_mem #(.CAPACITY(CAPACITY)) u_mem (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr),
    .rdata   (rdata)
  );

  fens_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .gt (cmp_gt)
  );

  fens_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .mem_ctl    (mem_ctl),
    .waddr      (waddr),
    .wdata      (wdata),
    .raddr      (raddr),
    .rdata      (rdata),
    .cmp_a      (cmp_a),
    .cmp_b      (cmp_b),
    .cmp_gt     (cmp_gt)
  );

  // an empty result is always the final one
  a_empty_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("empty result without final mark");

  // an empty result carries a zero word
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("empty result with nonzero data");

  // a filtered-out word that is not last frees the input at once
  a_drop_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast && in_tdata[0] && !in_tdata[DATA_W-1]
    |=> in_tready)
    else $error("input stalled after a filtered word");

endmodule

[tb/filter_even_negative_then_sort_tb.sv]
// Testbench for filter_even_negative_then_sort: streams runs of words, predicts
// the filtered, sorted result words and checks them field by field.
// Depends on fens_pkg and the filter_even_negative_then_sort RTL.
`timescale 1ns / 1ps

module filter_even_negative_then_sort_tb
  import fens_pkg::*;
();

  localparam int CAP        = DEF_CAPACITY;
  localparam int HOLD_LEN   = 300;
  localparam int SETTLE     = 8;
  localparam int MAX_REPORT = 10;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     fin;
    logic                     empty;
    logic                     ovf;
  } sort_result_t;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata   = '0;
  logic              in_tlast   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic              out_tlast;
  logic [1:0]        out_tuser;

  // sender and receiver idling, in percent
  int tx_gap_pct   = 0;
  int rx_stall_pct = 0;
  // long receiver hold-off, requested by the tests and served by the stall process
  int hold_asked   = 0;
  int hold_served  = 0;
  int hold_left    = 0;

  int errors = 0;

  // predictor state
  logic signed [DATA_W-1:0] kept_words [CAP];
  int                       kept_n      = 0;
  logic                     kept_lost   = 1'b0;
  sort_result_t             sorted_due_q[$];

  filter_even_negative_then_sort #(.CAPACITY(CAP)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("filter_even_negative_then_sort: mismatch");
    $finish;
  end

  // Filter one word into the sorted store; on last, queue the whole sorted run.
  function automatic void filter_and_insert(logic [DATA_W-1:0] word, logic is_last);
    logic signed [DATA_W-1:0] v;
    int                       pos;
    v = word;
    if (v[DATA_W-1] || !v[0]) begin
      if (kept_n >= CAP) begin
        kept_lost = 1'b1;
      end else begin
        pos = kept_n;
        while (pos > 0 && kept_words[pos-1] > v) begin
          kept_words[pos] = kept_words[pos-1];
          pos--;
        end
        kept_words[pos] = v;
        kept_n++;
      end
    end
    if (is_last) begin
      if (kept_n == 0) begin
        sorted_due_q.push_back('{'0, 1'b1, 1'b1, kept_lost});
      end else begin
        for (int i = 0; i < kept_n; i++)
          sorted_due_q.push_back('{kept_words[i], (i == kept_n - 1), 1'b0, kept_lost});
      end
      kept_n    = 0;
      kept_lost = 1'b0;
    end
  endfunction

  function automatic void note_mismatch(string msg);
    errors++;
    if (errors <= MAX_REPORT)
      $display("[%0t] %s", $realtime, msg);
  endfunction

  // result checker
  always @(posedge clk) begin
    sort_result_t got;
    sort_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata, out_tlast, out_tuser[0], out_tuser[1]};
      if (sorted_due_q.size() == 0) begin
        note_mismatch($sformatf("unexpected word: value=%0d last=%b empty=%b ovf=%b",
                                got.value, got.fin, got.empty, got.ovf));
      end else begin
        want = sorted_due_q.pop_front();
        if (got.value !== want.value || got.fin !== want.fin ||
            got.empty !== want.empty || got.ovf !== want.ovf)
          note_mismatch($sformatf(
            "exp value=%0d last=%b empty=%b ovf=%b, got value=%0d last=%b empty=%b ovf=%b",
            want.value, want.fin, want.empty, want.ovf,
            got.value, got.fin, got.empty, got.ovf));
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left   = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Offer one word and hold it until taken; in_tvalid stays high for back-to-back words.
  task automatic send_word(input logic [DATA_W-1:0] word, input logic is_last);
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tlast  <= is_last;
    do @(posedge clk); while (!in_tready);
    filter_and_insert(word, is_last);
    if ($urandom_range(99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every expected word has come out.
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sorted_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    logic [DATA_W-1:0] w;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(5))
          0: w = 32'h8000_0000;
          1: w = 32'h7FFF_FFFF;
          2: w = 32'h7FFF_FFFE;
          3: w = 32'hFFFF_FFFF;
          4: w = 32'h0000_0000;
          default: w = 32'h8000_0001;
        endcase
      end
      1, 2: w = $urandom_range(40) - 20;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic logic [DATA_W-1:0] rand_kept_word();
    logic [DATA_W-1:0] w;
    w = rand_word();
    if (!w[DATA_W-1])
      w[0] = 1'b0;
    return w;
  endfunction

  task automatic test_directed;
    // extremes, duplicates and filtered words in one run
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h7FFF_FFFE, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0001, 1'b0);
    send_word(32'hFFFF_FFFE, 1'b0);
    send_word(32'hFFFF_FFFE, 1'b0);
    send_word(32'h8000_0001, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'd100, 1'b0);
    send_word(32'd2, 1'b1);
    // only odd positive words: empty result
    send_word(32'd3, 1'b0);
    send_word(32'd5, 1'b0);
    send_word(32'd7, 1'b1);
    // single-word runs, kept and filtered
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'd1, 1'b1);
    // last word filtered out of a non-empty run
    send_word(32'd6, 1'b0);
    send_word(32'd9, 1'b1);
    drain();
  endtask

  task automatic test_capacity;
    // exactly full, no overflow
    for (int i = 0; i < CAP; i++)
      send_word(rand_kept_word(), i == CAP - 1);
    // overflow, with the last word filtered
    for (int i = 0; i < CAP + 6; i++)
      send_word(rand_kept_word(), 1'b0);
    send_word(32'd11, 1'b1);
    // flags must clear for the next run
    send_word(32'd13, 1'b1);
    drain();
  endtask

  task automatic test_random_runs(input int n_items);
    int counted;
    int len;
    counted = 0;
    while (counted < n_items) begin
      len = ($urandom_range(11) == 0) ? $urandom_range(40, 75) : $urandom_range(0, 9);
      // close the last run at the item budget
      if (len > n_items - counted - 1)
        len = n_items - counted - 1;
      for (int i = 0; i <= len; i++) begin
        send_word(rand_word(), i == len);
        counted++;
      end
    end
    drain();
  endtask

  task automatic test_backpressure;
    hold_asked++;
    // keep offering while the output is held: emission stalls and so does the input
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < 5; i++)
        send_word(rand_kept_word(), 1'b0);
      send_word(rand_word(), 1'b1);
    end
    drain();
  endtask

  task automatic test_drain_pause;
    for (int i = 0; i < 6; i++)
      send_word(rand_word(), 1'b0);
    send_word(rand_kept_word(), 1'b1);
    // pause until every word of the run has left, then resume
    drain();
    for (int i = 0; i < 4; i++)
      send_word(rand_word(), i == 3);
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_capacity();

    tx_gap_pct = 0;  rx_stall_pct = 0;
    test_random_runs(16);
    tx_gap_pct = 45; rx_stall_pct = 0;
    test_random_runs(16);
    tx_gap_pct = 0;  rx_stall_pct = 45;
    test_random_runs(16);
    tx_gap_pct = 32; rx_stall_pct = 32;
    test_random_runs(16);

    tx_gap_pct = 0;  rx_stall_pct = 0;
    test_backpressure();
    tx_gap_pct = 32; rx_stall_pct = 32;
    test_drain_pause();

    drain();
    if (errors == 0) begin
      $display("filter_even_negative_then_sort: match");
    end else begin
      $display("filter_even_negative_then_sort: mismatch");
    end
    $finish;
  end

endmodule
